/* sv/hsml_pkg.sv */
// ----------------------------------------------------------------------------
// hsml_pkg
// shared constants, types and the sequencer state set for the lookup block
// ----------------------------------------------------------------------------
package hsml_pkg;

    localparam int ImageWords = 8192;
    localparam int AddrW      = $clog2(ImageWords);
    localparam int MaxProbes  = 52;
    localparam int ProbeW     = $clog2(MaxProbes + 1);
    localparam logic [31:0] ProbeStep = 32'd113;
    localparam logic [31:0] EmptyKey  = 32'hFFFF_FFFF;

    localparam logic FuncLoad = 1'b0;
    localparam logic FuncPeek = 1'b1;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_len_rd,
        t_st_len_wait,
        t_st_probe_mod,
        t_st_key_rd,
        t_st_key_chk,
        t_st_sh_rd,
        t_st_sh_chk,
        t_st_nsh_chk,
        t_st_val_rd,
        t_st_val_chk,
        t_st_done
    } t_state;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

/* sv/hsml_ram.sv */
// ----------------------------------------------------------------------------
// hsml_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module hsml_ram #(
    parameter int Width = 32,
    parameter int Depth = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/hsml_mod.sv */
// ----------------------------------------------------------------------------
// hsml_mod
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hsml_mod
    import hsml_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [31:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_sh;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[31:0], r_num[31]};
        if (i_req.start) begin
            n_num  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[31:0];
endmodule

/* sv/hashed_sparse_matrix_lookup.sv */
// ----------------------------------------------------------------------------
// hashed_sparse_matrix_lookup
// two level open addressing lookup over a sparse matrix image in word memory
// ----------------------------------------------------------------------------
// One input stream (s_axis) carries load and peek items; tuser is func.
// A load writes one 32-bit word of the image and gives no result. A peek
// probes the row table, then that row's cell region, and gives one result
// item on m_axis: cell value in tdata, found flag in tuser.
// A load writes its word when it is taken, and loads can follow back to back. A
// peek first reads the row table length at word 0 and then probes: every probe
// runs the remainder unit against the table length, then one single-port memory
// read; a probe over a zero-width cell region skips the remainder unit. Up to 52
// probes per level; a found row key is followed by reads of that row's cell
// region bounds before the second level.
// Items are taken one at a time; s_axis_tready is low while a peek runs or
// while a result waits in the output register for m_axis_tready.
// Reset clears the sequencer and the output valid; the image memory is not
// cleared and must be loaded before it is peeked.
// ----------------------------------------------------------------------------
module hashed_sparse_matrix_lookup
    import hsml_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // word_address[12:0], word_value[44:13], row_key[76:45], col_key[108:77]
    input  logic [111:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_value[31:0]
    output logic [31:0] m_axis_tdata,
    // found
    output logic        m_axis_tuser
);
    t_state r_state, n_state;
    logic [31:0] r_row, n_row, r_col, n_col, r_key, n_key, r_len, n_len;
    logic [31:0] r_rlen, n_rlen, r_shift, n_shift;
    logic [33:0] r_base, n_base;    // signed word address of table
    logic [31:0] r_slot, n_slot;
    logic [ProbeW-1:0] r_n, n_n;
    logic        r_lvl, n_lvl;       // 0 row table, 1 cell table
    logic [34:0] r_addr, n_addr;    // signed computed address
    logic [31:0] r_ov, n_ov;
    logic        r_of, n_of, r_ovld, n_ovld;

    logic        w_we;
    logic [AddrW-1:0] w_ram_addr;
    logic [31:0] w_rdata, w_word;
    logic        r_oob, n_oob;
    t_div_req    w_req;
    t_div_rsp    w_rsp;
    logic [31:0] w_v, w_mag, w_lm;

    hsml_ram #(.Width(32), .Depth(ImageWords)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_ram_addr),
        .i_wdata(s_axis_tdata[44:13]),
        .o_rdata(w_rdata)
    );

    hsml_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // out-of-range reads give zero
    assign w_word = r_oob ? 32'd0 : w_rdata;
    assign s_axis_tready = (r_state == t_st_idle) && !r_ovld;

    always_comb begin
        w_v   = r_key + 32'(r_n) * ProbeStep;
        w_mag = w_v[31] ? (32'd0 - w_v) : w_v;
        w_lm  = r_len[31] ? (32'd0 - r_len) : r_len;
    end

    always_comb begin
        n_state = r_state;
        n_row = r_row; n_col = r_col; n_key = r_key; n_len = r_len;
        n_rlen = r_rlen; n_shift = r_shift; n_base = r_base; n_slot = r_slot;
        n_n = r_n; n_lvl = r_lvl; n_addr = r_addr;
        n_ov = r_ov; n_of = r_of; n_ovld = r_ovld;
        n_oob = 1'b0;
        w_we = 1'b0;
        w_ram_addr = r_addr[AddrW-1:0];
        w_req.start = 1'b0;
        w_req.dividend = w_mag;
        w_req.divisor = w_lm;
        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end
        unique case (r_state)
            t_st_idle: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tuser == FuncLoad) begin
                        w_ram_addr = s_axis_tdata[12:0];
                        w_we = 1'b1;
                    end else begin
                        n_row = s_axis_tdata[76:45];
                        n_col = s_axis_tdata[108:77];
                        n_state = t_st_len_rd;
                    end
                end
            end
            t_st_len_rd: begin
                w_ram_addr = '0;
                n_state = t_st_len_wait;
            end
            t_st_len_wait: begin
                n_rlen = w_word;
                n_len = w_word;
                n_key = r_row;
                n_base = 34'd2;
                n_n = '0;
                n_lvl = 1'b0;
                if (w_word == 32'd0) begin
                    n_ov = '0; n_of = 1'b0; n_state = t_st_done;
                end else begin
                    n_state = t_st_probe_mod;
                end
            end
            t_st_probe_mod: begin
                if (!w_rsp.busy && !w_rsp.done) begin
                    if (w_lm == 32'd0) begin
                        n_slot = '0;
                        n_addr = 35'(signed'(r_base));
                        n_state = t_st_key_rd;
                    end else begin
                        w_req.start = 1'b1;
                    end
                end else if (w_rsp.done) begin
                    n_slot = w_rsp.rem;
                    n_addr = 35'(signed'(r_base)) + {2'b0, w_rsp.rem, 1'b0};
                    n_state = t_st_key_rd;
                end
            end
            t_st_key_rd: begin
                n_oob = r_addr[34] || (r_addr >= 35'(ImageWords));
                n_state = t_st_key_chk;
            end
            t_st_key_chk: begin
                if (w_word == r_key) begin
                    n_addr = r_addr + 35'd1;
                    n_state = r_lvl ? t_st_val_rd : t_st_sh_rd;
                end else if (w_word == EmptyKey || 32'(r_n) == 32'(MaxProbes - 1)) begin
                    n_ov = '0; n_of = 1'b0; n_state = t_st_done;
                end else begin
                    n_n = r_n + 1'b1;
                    n_state = t_st_probe_mod;
                end
            end
            t_st_sh_rd: begin
                n_oob = r_addr[34] || (r_addr >= 35'(ImageWords));
                n_state = t_st_sh_chk;
            end
            t_st_sh_chk: begin
                n_shift = w_word;
                if ({1'b0, r_slot} == {1'b0, r_rlen} - 33'd1 && !r_rlen[31]) begin
                    n_addr = 35'd1;
                end else begin
                    n_addr = r_addr + 35'd2;
                end
                n_state = t_st_nsh_chk;
            end
            t_st_nsh_chk: begin
                // first pass waits for the next shift read, second pass uses it
                if (r_lvl) begin
                    n_len = w_word - r_shift;
                    n_key = r_col;
                    n_base = 34'(signed'({r_rlen, 1'b0})) + 34'd2
                        + 34'(signed'({r_shift, 1'b0}));
                    n_n = '0;
                    n_state = t_st_probe_mod;
                    n_lvl = 1'b1;
                end else begin
                    n_oob = r_addr[34] || (r_addr >= 35'(ImageWords));
                    n_lvl = 1'b1;
                end
            end
            t_st_val_rd: begin
                n_oob = r_addr[34] || (r_addr >= 35'(ImageWords));
                n_state = t_st_val_chk;
            end
            t_st_val_chk: begin
                n_ov = w_word; n_of = 1'b1; n_state = t_st_done;
            end
            t_st_done: begin
                if (!r_ovld) begin
                    n_ovld = 1'b1;
                    n_state = t_st_idle;
                end
            end
            default: n_state = t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
            r_ovld  <= 1'b0;
            r_lvl   <= 1'b0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_lvl   <= n_lvl;
            r_n     <= n_n;
        end
        r_row <= n_row; r_col <= n_col; r_key <= n_key; r_len <= n_len;
        r_rlen <= n_rlen; r_shift <= n_shift; r_base <= n_base;
        r_slot <= n_slot; r_addr <= n_addr;
        r_ov <= n_ov; r_of <= n_of; r_oob <= n_oob;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_ov;
    assign m_axis_tuser  = r_of;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_st_idle) |-> !s_axis_tready) else $error("take while busy");
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("not found with value");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_n) < 32'(MaxProbes)) else $error("probe overrun");
`endif
endmodule
